>>> design/nv21_pkg.sv
// shared types and fixed-point constants of the nv21 to rgb24 converter
package nv21_pkg;

  // fixed widths of the item fields
  localparam int SAMPLE_W = 8;
  localparam int CFG_W    = 13;
  localparam int POS_W    = 12;

  // bt.601 coefficients, 16-bit fraction
  localparam int LUMA_GAIN  = 76309;
  localparam int CR_GAIN    = 104597;
  localparam int CG_U_GAIN  = 25675;
  localparam int CG_V_GAIN  = 53279;
  localparam int CB_GAIN    = 132201;
  localparam int LUMA_BLACK = 16;
  localparam int CHROMA_MID = 128;

  // signed width of one scaled term and of a pixel sum
  localparam int TERM_W = 27;
  localparam int SUM_W  = 28;

  // register map
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // block queue depth between front and back
  localparam int QDEPTH = 2;

  // pixel order inside a block
  localparam logic [1:0] PIX_TOP_LEFT     = 2'd0;
  localparam logic [1:0] PIX_BOTTOM_RIGHT = 2'd3;

  // colour part of one queued block
  typedef struct packed {
    logic [3:0][SAMPLE_W-1:0] luma;   // tl, bl, tr, br
    logic signed [TERM_W-1:0] cr;
    logic signed [TERM_W-1:0] g_u;
    logic signed [TERM_W-1:0] g_v;
    logic signed [TERM_W-1:0] cb;
  } blk_color_t;

endpackage

>>> design/nv21_queue.sv
// short fifo of block requests between the front and the back
module nv21_queue #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         q_full,
  output logic         q_empty
);
  import nv21_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  logic [W-1:0]    mem [QDEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CNTW'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/nv21_front.sv
// front: accepts blocks, scales chroma and tracks the frame position
module nv21_front #(
  parameter int CW = 12,
  parameter int DW = 13,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_y_top_left,
  input  logic [7:0]    in_y_bottom_left,
  input  logic [7:0]    in_y_top_right,
  input  logic [7:0]    in_y_bottom_right,
  input  logic [7:0]    in_chroma_v,
  input  logic [7:0]    in_chroma_u,
  input  logic [DW-1:0] eff_width,
  input  logic [DW-1:0] eff_height,
  input  logic          q_full,
  output logic          q_wr_en,
  output logic [QW-1:0] q_wr_data
);
  import nv21_pkg::*;

  localparam int XW = DW + 1;

  logic [CW-1:0] block_column_r, block_column_nxt;
  logic [CW-1:0] row_pair_start_r, row_pair_start_nxt;
  logic          accept;
  logic          row_end;
  logic          frame_end;
  logic signed [SAMPLE_W:0] dv;
  logic signed [SAMPLE_W:0] du;
  blk_color_t    color;

  assign full   = q_full;
  assign accept = push && !q_full;

  assign row_end   = (XW'(block_column_r) + XW'(2)) >= XW'(eff_width);
  assign frame_end = row_end && ((XW'(row_pair_start_r) + XW'(2)) >= XW'(eff_height));

  // chroma centred on zero, then scaled once per block
  assign dv = $signed({1'b0, in_chroma_v}) - (SAMPLE_W+1)'(CHROMA_MID);
  assign du = $signed({1'b0, in_chroma_u}) - (SAMPLE_W+1)'(CHROMA_MID);

  always_comb begin
    color.luma = {in_y_bottom_right, in_y_top_right, in_y_bottom_left, in_y_top_left};
    color.cr   = TERM_W'(dv * CR_GAIN);
    color.g_u  = TERM_W'(du * CG_U_GAIN);
    color.g_v  = TERM_W'(dv * CG_V_GAIN);
    color.cb   = TERM_W'(du * CB_GAIN);
  end

  assign q_wr_en   = accept;
  assign q_wr_data = {frame_end, row_pair_start_r, block_column_r, color};

  always_comb begin
    block_column_nxt   = block_column_r;
    row_pair_start_nxt = row_pair_start_r;
    if (accept) begin
      if (frame_end) begin
        block_column_nxt   = '0;
        row_pair_start_nxt = '0;
      end else if (row_end) begin
        block_column_nxt   = '0;
        row_pair_start_nxt = row_pair_start_r + CW'(2);
      end else begin
        block_column_nxt   = block_column_r + CW'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_column_r   <= '0;
      row_pair_start_r <= '0;
    end else begin
      block_column_r   <= block_column_nxt;
      row_pair_start_r <= row_pair_start_nxt;
    end
  end

endmodule

>>> design/nv21_back.sv
// back: walks each queued block pixel by pixel through luma scale and clamp
module nv21_back #(
  parameter int CW = 12,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [QW-1:0] q_rd_data,
  output logic          q_rd_en,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic [11:0]   out_pixel_column,
  output logic [11:0]   out_pixel_row,
  output logic          out_last_of_block,
  output logic          out_end_of_frame
);
  import nv21_pkg::*;

  localparam int CLW = $bits(blk_color_t);

  function automatic logic [7:0] clamp_pix(input logic signed [SUM_W-1:0] x);
    logic [7:0] res;
    if (x[SUM_W-1]) begin
      res = 8'd0;
    end else if (|x[SUM_W-2:24]) begin
      res = 8'd255;
    end else begin
      res = x[23:16];
    end
    return res;
  endfunction

  blk_color_t    color;
  logic [CW-1:0] blk_col;
  logic [CW-1:0] blk_row;
  logic          blk_eof;

  logic [1:0] sq_r, sq_nxt;
  logic       issue;
  logic       s1_ready;
  logic       s2_ready;

  logic                     s1_v_r, s1_v_nxt;
  logic signed [TERM_W-1:0] s1_yy_r;
  logic signed [TERM_W-1:0] s1_cr_r, s1_gu_r, s1_gv_r, s1_cb_r;
  logic [POS_W-1:0]         s1_col_r, s1_row_r;
  logic                     s1_last_r, s1_eof_r;

  logic                     s2_v_r, s2_v_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic signed [SAMPLE_W:0] ym;

  assign color   = q_rd_data[CLW-1:0];
  assign blk_col = q_rd_data[CLW +: CW];
  assign blk_row = q_rd_data[CLW+CW +: CW];
  assign blk_eof = q_rd_data[CLW+2*CW];

  assign s2_ready = !s2_v_r || pop;
  assign s1_ready = !s1_v_r || s2_ready;
  assign issue    = !q_empty && s1_ready;
  assign q_rd_en  = issue && (sq_r == PIX_BOTTOM_RIGHT);

  assign sq_nxt   = issue ? sq_r + 2'd1 : sq_r;
  assign s1_v_nxt = s1_ready ? issue : s1_v_r;
  assign s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;

  assign ym = $signed({1'b0, color.luma[sq_r]}) - (SAMPLE_W+1)'(LUMA_BLACK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r   <= PIX_TOP_LEFT;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      sq_r   <= sq_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // stage 1: luma scale; bit 0 of the pixel index is the row step, bit 1 the column step
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_yy_r   <= TERM_W'(ym * LUMA_GAIN);
      s1_cr_r   <= color.cr;
      s1_gu_r   <= color.g_u;
      s1_gv_r   <= color.g_v;
      s1_cb_r   <= color.cb;
      s1_col_r  <= POS_W'(blk_col + CW'(sq_r[1]));
      s1_row_r  <= POS_W'(blk_row + CW'(sq_r[0]));
      s1_last_r <= (sq_r == PIX_BOTTOM_RIGHT);
      s1_eof_r  <= (sq_r == PIX_BOTTOM_RIGHT) && blk_eof;
    end
  end

  assign sum_r = SUM_W'(s1_yy_r) + SUM_W'(s1_cr_r);
  assign sum_g = SUM_W'(s1_yy_r) - SUM_W'(s1_gu_r) - SUM_W'(s1_gv_r);
  assign sum_b = SUM_W'(s1_yy_r) + SUM_W'(s1_cb_r);

  // stage 2: sums and clamp into the output register
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      out_red           <= clamp_pix(sum_r);
      out_green         <= clamp_pix(sum_g);
      out_blue          <= clamp_pix(sum_b);
      out_pixel_column  <= s1_col_r;
      out_pixel_row     <= s1_row_r;
      out_last_of_block <= s1_last_r;
      out_end_of_frame  <= s1_eof_r;
    end
  end

  assign empty = !s2_v_r;

endmodule

>>> design/nv21_to_rgb24_converter_top.sv
// top level of the nv21 to rgb24 converter
//
// usage:
//   input queue: drive one 2x2 luma block with its v,u chroma pair and raise
//   push; the request is taken at an edge where push is high and full is low
//   output queue: while empty is low the oldest pixel sits on the out_ ports;
//   pop at an edge with empty low takes it. pixels leave in the order
//   top-left, bottom-left, top-right, bottom-right
//   config: apb-style writes to frame_width (byte 0) and frame_height
//   (byte 4), only while the block is idle; pready is tied high
// timing:
//   a taken request passes the block queue, stage 1 and stage 2 before its
//   first pixel shows; the four pixels follow one per cycle when pop stays
//   high, one at a time through the single luma multiplier of the back stage
// reset:
//   rst_n low clears the frame walk to the top-left corner, empties both
//   queues and loads 640 x 480
// stalls:
//   when pop stays low the pixel pipe holds, the two-entry block queue fills
//   and full rises; nothing is dropped
module nv21_to_rgb24_converter_top #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // input request channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_y_top_left,
  input  logic [7:0]  in_y_bottom_left,
  input  logic [7:0]  in_y_top_right,
  input  logic [7:0]  in_y_bottom_right,
  input  logic [7:0]  in_chroma_v,
  input  logic [7:0]  in_chroma_u,
  // pixel channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [11:0] out_pixel_column,
  output logic [11:0] out_pixel_row,
  output logic        out_last_of_block,
  output logic        out_end_of_frame,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nv21_pkg::*;

  // counter width and effective size width follow from the size limit
  localparam int CW = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int XW = ((DW > CFG_W) ? DW : CFG_W) + 1;
  localparam int MAX_EVEN = MAX_DIMENSION - (MAX_DIMENSION % 2);
  localparam int QW = $bits(blk_color_t) + 2 * CW + 1;

  // bit 0 ignored, zero acts as 2, clipped to the even size limit
  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] reg_val);
    logic [XW-1:0] d;
    d = XW'({reg_val[CFG_W-1:1], 1'b0});
    if (d == '0) begin
      d = XW'(2);
    end else if (d > XW'(MAX_DIMENSION)) begin
      d = XW'(MAX_EVEN);
    end
    return DW'(d);
  endfunction

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic             cfg_wr;
  logic [DW-1:0]    eff_width;
  logic [DW-1:0]    eff_height;

  logic          q_wr_en;
  logic [QW-1:0] q_wr_data;
  logic          q_rd_en;
  logic [QW-1:0] q_rd_data;
  logic          q_full;
  logic          q_empty;

  // register file; decode on the word select bit only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  assign eff_width  = eff_dim(frame_width_r);
  assign eff_height = eff_dim(frame_height_r);

  // front: takes requests, scales chroma, walks the frame
  nv21_front #(
    .CW (CW),
    .DW (DW),
    .QW (QW)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_y_top_left     (in_y_top_left),
    .in_y_bottom_left  (in_y_bottom_left),
    .in_y_top_right    (in_y_top_right),
    .in_y_bottom_right (in_y_bottom_right),
    .in_chroma_v       (in_chroma_v),
    .in_chroma_u       (in_chroma_u),
    .eff_width         (eff_width),
    .eff_height        (eff_height),
    .q_full            (q_full),
    .q_wr_en           (q_wr_en),
    .q_wr_data         (q_wr_data)
  );

  // two-entry block queue lets front and back stall independently
  nv21_queue #(
    .W (QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back: four pixels per block through a two-stage pipe
  nv21_back #(
    .CW (CW),
    .QW (QW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rd_data         (q_rd_data),
    .q_rd_en           (q_rd_en),
    .empty             (empty),
    .pop               (pop),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_pixel_column  (out_pixel_column),
    .out_pixel_row     (out_pixel_row),
    .out_last_of_block (out_last_of_block),
    .out_end_of_frame  (out_end_of_frame)
  );

endmodule

>>> design/nv21_checker.sv
// port-level checks of the converter and their bind to the top level
module nv21_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_red,
  input logic [11:0] out_pixel_column,
  input logic [11:0] out_pixel_row,
  input logic        out_last_of_block,
  input logic        out_end_of_frame
);

  // reset leaves no pixel waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("pixel queue not empty after reset");

  // frame end only on the last pixel of a block
  a_eof_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_end_of_frame) |-> out_last_of_block)
    else $error("end_of_frame without last_of_block");

  // last pixel of a block is the bottom-right one: odd column and row
  a_last_odd_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_of_block) |-> (out_pixel_column[0] && out_pixel_row[0]))
    else $error("last_of_block at an even position");

  // a waiting pixel holds while not popped
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_red) && $stable(out_pixel_column)))
    else $error("waiting pixel changed");

endmodule

bind nv21_to_rgb24_converter_top nv21_checker u_nv21_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .empty             (empty),
  .pop               (pop),
  .out_red           (out_red),
  .out_pixel_column  (out_pixel_column),
  .out_pixel_row     (out_pixel_row),
  .out_last_of_block (out_last_of_block),
  .out_end_of_frame  (out_end_of_frame)
);
